@@ sv/cfbf_pkg.sv @@
// Package for the CAN frame byte FIFO: buffer geometry, payload structs,
// operation codes, lane flag struct and the controller state type.
// No dependencies; every other file of the block imports it.
package cfbf_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int PTR_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int NUM_LANES = 8;
  localparam int LANE_W    = $clog2(NUM_LANES);
  localparam int ID_W      = 11;

  // Operation codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Position of the extended-format flag in the second identifier byte.
  localparam int IDE_BIT = 3;

  typedef struct packed {
    logic        operation;
    logic [7:0]  id_reg_high;
    logic [7:0]  id_reg_low;
    logic [3:0]  length_code;
    logic [63:0] frame_data;
  } in_req_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       frame_taken;
    logic [3:0] bytes_stored;
    logic [3:0] bytes_dropped;
    logic [6:0] free_slots;
  } out_rsp_t;

  // What one byte lane found about its byte.
  typedef struct packed {
    logic keep;  // byte belongs to an accepted frame
    logic fits;  // buffer has room for it
  } lane_flag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_POP
  } cfbf_state_t;

endpackage

@@ sv/cfbf_lane.sv @@
// One byte lane: decides whether its byte of a frame is queued or dropped.
// Depends on cfbf_pkg.
module cfbf_lane (
  input  logic [cfbf_pkg::LANE_W-1:0] lane_idx,
  input  logic                        taken,
  input  logic [3:0]                  length_code,
  input  logic [cfbf_pkg::CNT_W-1:0]  free_cnt,
  output cfbf_pkg::lane_flag_t        flag
);
  import cfbf_pkg::*;

  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  // A length code above eight covers every lane, which is the same as eight.
  always_comb begin
    flag.keep = taken && (CMP_W'(lane_idx) < CMP_W'(length_code));
    flag.fits = CMP_W'(lane_idx) < CMP_W'(free_cnt);
  end

endmodule

@@ sv/cfbf_merge.sv @@
// Merging stage: counts the bytes the lanes will store and drop.
// Depends on cfbf_pkg.
module cfbf_merge (
  input  cfbf_pkg::lane_flag_t [cfbf_pkg::NUM_LANES-1:0] flags,
  output logic [3:0]                                     stored_cnt,
  output logic [3:0]                                     dropped_cnt
);
  import cfbf_pkg::*;

  logic [NUM_LANES-1:0] store_vec;
  logic [NUM_LANES-1:0] drop_vec;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      store_vec[k] = flags[k].keep & flags[k].fits;
      drop_vec[k]  = flags[k].keep & ~flags[k].fits;
    end
    stored_cnt  = 4'($countones(store_vec));
    dropped_cnt = 4'($countones(drop_vec));
  end

endmodule

@@ sv/cfbf_store.sv @@
// Byte storage of the ring buffer: one write port, one registered read port.
// Depends on cfbf_pkg.
module cfbf_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [cfbf_pkg::PTR_W-1:0] wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic                       rd_en,
  input  logic [cfbf_pkg::PTR_W-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import cfbf_pkg::*;

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/can_frame_byte_fifo.sv @@
// Top level of the CAN frame byte FIFO: request decode, byte lanes, merge,
// write sequencer and ring pointers. Depends on cfbf_pkg, cfbf_lane,
// cfbf_merge and cfbf_store.
//
// Usage. A request is taken at a clock edge where start is high and busy is
// low; in_req carries the operation and the raw frame fields. A push request
// carries a received frame. It is taken when the extended-format bit is clear
// and its 11-bit identifier equals the configured one; eight byte lanes then
// decide in parallel, for the first length-code bytes, which fit in the free
// space and which are dropped. The stored bytes go into the buffer one per
// cycle, and the push gives its result once the last stored byte is written. A
// pop request reads the oldest byte through the registered read port of the
// byte store and gives its result in the cycle after the request; an
// empty buffer gives a result with byte_valid low. Busy is high from the
// cycle after the accepted request through the result cycle, so one request
// is in flight and a new one is taken only once the block is idle again. Every
// request gives exactly one result, shown on out_rsp for one cycle with
// out_strobe high; the receiver cannot stall. The user must write the
// identifier register through cfg_we and cfg_wdata only while the block is
// idle; the block itself does not enforce it. Reset (rst_n low, synchronous)
// empties the buffer, zeroes the identifier and makes the block idle; buffer
// contents are not cleared, since only written entries are ever read.
module can_frame_byte_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  cfbf_pkg::in_req_t         in_req,
  output logic                      out_strobe,
  output cfbf_pkg::out_rsp_t        out_rsp,
  input  logic                      cfg_we,
  input  logic [cfbf_pkg::ID_W-1:0] cfg_wdata
);
  import cfbf_pkg::*;

  // Control state.
  cfbf_state_t      state_r, state_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic [3:0]       wr_left_r, wr_left_nxt;
  logic [ID_W-1:0]  acc_id_r;

  // Payload held for the request in flight.
  logic [63:0]      data_r, data_nxt;
  logic             taken_r, taken_nxt;
  logic [3:0]       stored_r, stored_nxt;
  logic [3:0]       dropped_r, dropped_nxt;
  logic             byte_valid_r, byte_valid_nxt;

  logic             req_accept;
  logic             frame_ok;
  logic             buf_empty;
  logic             pop_rd;
  logic             wr_en;
  logic [7:0]       rd_byte;
  logic [3:0]       lane_stored;
  logic [3:0]       lane_dropped;
  lane_flag_t [NUM_LANES-1:0] lane_flags;

  assign req_accept = start && !busy;
  assign buf_empty  = (free_r == CNT_W'(BUF_DEPTH));

  // The identifier is split across both register bytes; the extended-format
  // flag rejects the frame outright. The remote request bit is ignored.
  assign frame_ok = !in_req.id_reg_low[IDE_BIT] &&
                    ({in_req.id_reg_high, in_req.id_reg_low[7:5]} == acc_id_r);

  // Eight lanes, one per data byte, all looking at the same free count.
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    cfbf_lane u_lane (
      .lane_idx    (LANE_W'(k)),
      .taken       (frame_ok),
      .length_code (in_req.length_code),
      .free_cnt    (free_r),
      .flag        (lane_flags[k])
    );
  end

  cfbf_merge u_merge (
    .flags       (lane_flags),
    .stored_cnt  (lane_stored),
    .dropped_cnt (lane_dropped)
  );

  // Stored bytes are always the leading ones, so the sequencer just writes
  // the low byte of the held data and shifts it down.
  assign wr_en  = (state_r == ST_WRITE) && (wr_left_r != 4'd0);
  assign pop_rd = req_accept && (in_req.operation == OP_POP) && !buf_empty;

  cfbf_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (data_r[7:0]),
    .rd_en   (pop_rd),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_byte)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_accept) begin
          state_nxt = (in_req.operation == OP_POP) ? ST_POP : ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (wr_left_r == 4'd0) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and pointer updates.
  always_comb begin
    wr_ptr_nxt     = wr_ptr_r;
    rd_ptr_nxt     = rd_ptr_r;
    free_nxt       = free_r;
    wr_left_nxt    = wr_left_r;
    data_nxt       = data_r;
    taken_nxt      = taken_r;
    stored_nxt     = stored_r;
    dropped_nxt    = dropped_r;
    byte_valid_nxt = byte_valid_r;
    if (req_accept) begin
      data_nxt       = in_req.frame_data;
      taken_nxt      = frame_ok;
      stored_nxt     = lane_stored;
      dropped_nxt    = lane_dropped;
      wr_left_nxt    = (in_req.operation == OP_PUSH) ? lane_stored : 4'd0;
      byte_valid_nxt = pop_rd;
      if (pop_rd) begin
        rd_ptr_nxt = (rd_ptr_r == PTR_W'(BUF_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
        free_nxt   = free_r + 1'b1;
      end
    end else if (wr_en) begin
      wr_ptr_nxt  = (wr_ptr_r == PTR_W'(BUF_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      free_nxt    = free_r - 1'b1;
      wr_left_nxt = wr_left_r - 4'd1;
      data_nxt    = {8'd0, data_r[63:8]};
    end
  end

  // Outputs.
  always_comb begin
    busy       = (state_r != ST_IDLE);
    out_strobe = 1'b0;
    out_rsp    = '0;
    case (state_r)
      ST_WRITE: begin
        if (wr_left_r == 4'd0) begin
          out_strobe            = 1'b1;
          out_rsp.frame_taken   = taken_r;
          out_rsp.bytes_stored  = stored_r;
          out_rsp.bytes_dropped = dropped_r;
          out_rsp.free_slots    = 7'(free_r);
        end
      end
      ST_POP: begin
        out_strobe         = 1'b1;
        out_rsp.byte_valid = byte_valid_r;
        out_rsp.byte_out   = byte_valid_r ? rd_byte : 8'd0;
        out_rsp.free_slots = 7'(free_r);
      end
      default: begin
        out_strobe = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      free_r    <= CNT_W'(BUF_DEPTH);
      wr_left_r <= 4'd0;
      acc_id_r  <= '0;
    end else begin
      state_r   <= state_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      free_r    <= free_nxt;
      wr_left_r <= wr_left_nxt;
      if (cfg_we) begin
        acc_id_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r       <= data_nxt;
    taken_r      <= taken_nxt;
    stored_r     <= stored_nxt;
    dropped_r    <= dropped_nxt;
    byte_valid_r <= byte_valid_nxt;
  end

  // A byte is only ever written into free space.
  a_write_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (free_r != '0))
    else $error("write with full buffer");

  // A valid pop result means exactly one entry was freed by that request.
  a_pop_frees_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_rsp.byte_valid) |-> (free_r == $past(free_r) + 1'b1))
    else $error("pop did not free one entry");

  // A frame never accounts for more than eight bytes.
  a_byte_budget: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (5'(out_rsp.bytes_stored) + 5'(out_rsp.bytes_dropped) <= 5'd8))
    else $error("stored plus dropped exceeds eight");

  // An accepted request always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req_accept |=> busy)
    else $error("accepted request did not raise busy");

  // The free count stays within the buffer depth.
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= CNT_W'(BUF_DEPTH))
    else $error("free count above depth");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for can_frame_byte_fifo: a directed request table, then
// random push and pop requests checked against a behavioral model of the ring buffer.
// Depends on cfbf_pkg and can_frame_byte_fifo.
module tb;
  import cfbf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_REQS  = 175;

  // One row of the directed table. When wr_id is set, the identifier register
  // is written with id once the block is idle, before the request goes out.
  // When known is set, rsp is the expected result typed in by hand; otherwise
  // the buffer model decides.
  typedef struct {
    logic            wr_id;
    logic [ID_W-1:0] id;
    in_req_t         req;
    logic            known;
    out_rsp_t        rsp;
  } dir_row_t;

  typedef struct packed {
    logic     known;
    out_rsp_t rsp;
  } typed_rsp_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            start;
  logic            busy;
  in_req_t         in_req;
  logic            out_strobe;
  out_rsp_t        out_rsp;
  logic            cfg_we;
  logic [ID_W-1:0] cfg_wdata;

  // Model of the buffer: byte store, ring pointers, free count and the
  // identifier filter.
  logic [7:0]      shadow_bytes [BUF_DEPTH];
  int              wr_ptr;
  int              rd_ptr;
  int              free_cnt;
  logic [ID_W-1:0] id_filter;

  dir_row_t   dir_tab[$];
  typed_rsp_t dir_rsp_q[$];   // Hand-typed results of directed requests, in order.
  out_rsp_t   fifo_rsp_q[$];  // Results owed by the block, oldest first.
  int         fail_cnt  = 0;
  int         cycle_cnt = 0;
  int         pop_pcts [NUM_PHASES] = '{40, 60, 50, 30, 70, 50};

  can_frame_byte_fifo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Applies one request to the buffer model and returns the result it owes.
  // A pop of an empty buffer leaves the state alone; a push that is not
  // standard format or carries another identifier is dropped whole; a length
  // code above eight counts as eight, and bytes beyond the free space are lost.
  function automatic out_rsp_t predict_fifo_rsp(in_req_t r);
    out_rsp_t        rsp;
    logic [ID_W-1:0] frame_id;
    int              n_bytes;
    rsp = '0;
    if (r.operation == OP_POP) begin
      if (free_cnt < BUF_DEPTH) begin
        rsp.byte_out   = shadow_bytes[rd_ptr];
        rsp.byte_valid = 1'b1;
        rd_ptr         = (rd_ptr + 1) % BUF_DEPTH;
        free_cnt++;
      end
    end else begin
      frame_id = {r.id_reg_high, r.id_reg_low[7:5]};
      if (!r.id_reg_low[IDE_BIT] && frame_id == id_filter) begin
        rsp.frame_taken = 1'b1;
        n_bytes = (r.length_code > 4'd8) ? 8 : int'(r.length_code);
        for (int k = 0; k < n_bytes; k++) begin
          if (free_cnt != 0) begin
            shadow_bytes[wr_ptr] = r.frame_data[8*k +: 8];
            wr_ptr = (wr_ptr + 1) % BUF_DEPTH;
            free_cnt--;
            rsp.bytes_stored = rsp.bytes_stored + 4'd1;
          end else begin
            rsp.bytes_dropped = rsp.bytes_dropped + 4'd1;
          end
        end
      end
    end
    rsp.free_slots = free_cnt[6:0];
    return rsp;
  endfunction

  function automatic void add_row(logic wr_id, logic [ID_W-1:0] id, in_req_t req,
                                  logic known, out_rsp_t rsp);
    dir_row_t row;
    row.wr_id = wr_id;
    row.id    = id;
    row.req   = req;
    row.known = known;
    row.rsp   = rsp;
    dir_tab.push_back(row);
  endfunction

  // Drives a request and returns at the clock edge that accepts it. Busy is
  // looked at on the falling edge, where it has settled, so the decision does
  // not depend on event order at the rising edge.
  task automatic send_request(input in_req_t r);
    start  <= 1'b1;
    in_req <= r;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  // Holds requests back until every owed result has arrived and the block is idle.
  task automatic drain_fifo_rsp();
    start <= 1'b0;
    do @(negedge clk); while (fifo_rsp_q.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_filter_id(input logic [ID_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Checker and request monitor. Results are compared first: the block never
  // answers at the same edge that takes its request, so the order is safe.
  // Then a register write updates the filter, and an accepted request is run
  // through the model, with a hand-typed result taking its place where present.
  always @(posedge clk) begin
    out_rsp_t   exp_rsp;
    typed_rsp_t typed;
    if (rst_n) begin
      if (out_strobe) begin
        if (fifo_rsp_q.size() == 0) begin
          if (fail_cnt < 10)
            $display("unexpected result at cycle %0d: byte %h valid %b free %0d",
                     cycle_cnt, out_rsp.byte_out, out_rsp.byte_valid, out_rsp.free_slots);
          fail_cnt++;
        end else begin
          exp_rsp = fifo_rsp_q.pop_front();
          if (out_rsp.byte_out      !== exp_rsp.byte_out      ||
              out_rsp.byte_valid    !== exp_rsp.byte_valid    ||
              out_rsp.frame_taken   !== exp_rsp.frame_taken   ||
              out_rsp.bytes_stored  !== exp_rsp.bytes_stored  ||
              out_rsp.bytes_dropped !== exp_rsp.bytes_dropped ||
              out_rsp.free_slots    !== exp_rsp.free_slots) begin
            if (fail_cnt < 10)
              $display({"mismatch at cycle %0d (expected/actual): byte %h/%h valid %b/%b",
                        " taken %b/%b stored %0d/%0d dropped %0d/%0d free %0d/%0d"},
                       cycle_cnt, exp_rsp.byte_out, out_rsp.byte_out,
                       exp_rsp.byte_valid, out_rsp.byte_valid,
                       exp_rsp.frame_taken, out_rsp.frame_taken,
                       exp_rsp.bytes_stored, out_rsp.bytes_stored,
                       exp_rsp.bytes_dropped, out_rsp.bytes_dropped,
                       exp_rsp.free_slots, out_rsp.free_slots);
            fail_cnt++;
          end
        end
      end
      if (cfg_we)
        id_filter = cfg_wdata;
      if (start && !busy) begin
        exp_rsp = predict_fifo_rsp(in_req);
        if (dir_rsp_q.size() != 0) begin
          typed = dir_rsp_q.pop_front();
          if (typed.known)
            exp_rsp = typed.rsp;
        end
        fifo_rsp_q.push_back(exp_rsp);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    in_req_t         r;
    logic [ID_W-1:0] id_now;

    // Directed part, identifier filter at its reset value of zero first.
    // Empty pop, empty frame, a full frame, an extended frame, a foreign
    // identifier, a clamped length code, a remote frame and a pop.
    add_row(0, '0, in_req_t'{OP_POP, 8'h00, 8'h00, 4'd0, 64'h0},
            1, out_rsp_t'{8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 7'd64});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd0, 64'h0},
            1, out_rsp_t'{8'h00, 1'b0, 1'b1, 4'd0, 4'd0, 7'd64});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'h0123_4567_89AB_CDEF},
            1, out_rsp_t'{8'h00, 1'b0, 1'b1, 4'd8, 4'd0, 7'd56});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h08, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF},
            1, out_rsp_t'{8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 7'd56});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'hFF, 8'h00, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF},
            1, out_rsp_t'{8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 7'd56});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF},
            1, out_rsp_t'{8'h00, 1'b0, 1'b1, 4'd8, 4'd0, 7'd48});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h10, 4'd3, 64'h5A5A_5A5A_00A5_C33C},
            1, out_rsp_t'{8'h00, 1'b0, 1'b1, 4'd3, 4'd0, 7'd45});
    add_row(0, '0, in_req_t'{OP_POP, 8'hFF, 8'hFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF},
            1, out_rsp_t'{8'hEF, 1'b1, 1'b0, 4'd0, 4'd0, 7'd46});
    // Identifier low bits below the flags are ignored.
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h17, 4'd4, 64'h8000_0000_1122_3344},
            0, '0);
    // Fill the buffer to the brim, then overflow it partly and completely.
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'hAAAA_5555_AAAA_5555},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'h5555_AAAA_5555_AAAA},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd9, 64'h0F0F_F0F0_3C3C_C3C3},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'h0102_0408_1020_4080},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'hFEDC_BA98_7654_3210},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'h7766_5544_3322_1100},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h04, 4'd8, 64'h1357_9BDF_2468_ACE0},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'hDEAD_BEEF_CAFE_F00D},
            1, out_rsp_t'{8'h00, 1'b0, 1'b1, 4'd0, 4'd8, 7'd0});
    add_row(0, '0, in_req_t'{OP_POP, 8'h00, 8'h00, 4'd0, 64'h0}, 0, '0);
    // Identifier filter at its top value.
    add_row(1, '1, in_req_t'{OP_PUSH, 8'hFF, 8'hE0, 4'd1, 64'h0000_0000_0000_0077},
            0, '0);
    add_row(0, '0, in_req_t'{OP_PUSH, 8'hFF, 8'hE8, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF},
            1, out_rsp_t'{8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 7'd0});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'h00, 8'h00, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF},
            1, out_rsp_t'{8'h00, 1'b0, 1'b0, 4'd0, 4'd0, 7'd0});
    add_row(0, '0, in_req_t'{OP_PUSH, 8'hFF, 8'hF7, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF},
            0, '0);
    add_row(0, '0, in_req_t'{OP_POP, 8'h00, 8'h00, 4'd0, 64'h0}, 0, '0);

    // Every input is known from time zero; the model starts empty.
    rst_n     = 1'b0;
    start     = 1'b0;
    in_req    = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    wr_ptr    = 0;
    rd_ptr    = 0;
    free_cnt  = BUF_DEPTH;
    id_filter = '0;
    foreach (shadow_bytes[i])
      shadow_bytes[i] = 8'h00;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_id) begin
        drain_fifo_rsp();
        write_filter_id(dir_tab[i].id);
      end
      dir_rsp_q.push_back({dir_tab[i].known, dir_tab[i].rsp});
      send_request(dir_tab[i].req);
    end
    drain_fifo_rsp();

    // Random part. Each phase runs with its own filter identifier and pop
    // rate, so the buffer swings between empty and full. Most frames carry
    // the filter identifier and the standard-format flag so that they reach
    // the buffer; the rest are rejected frames. The last phase sends back to
    // back with no idle cycles.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       id_now = '0;
        1:       id_now = '1;
        default: id_now = ID_W'($urandom);
      endcase
      write_filter_id(id_now);
      for (int n = 0; n < PHASE_REQS; n++) begin
        r.operation   = ($urandom_range(99) < pop_pcts[p]) ? OP_POP : OP_PUSH;
        r.id_reg_high = 8'($urandom);
        r.id_reg_low  = 8'($urandom);
        r.length_code = 4'($urandom);
        r.frame_data  = {$urandom, $urandom};
        if ($urandom_range(99) < 75)
          {r.id_reg_high, r.id_reg_low[7:5]} = id_now;
        r.id_reg_low[IDE_BIT] = ($urandom_range(99) < 15);
        if (p != NUM_PHASES - 1 && $urandom_range(99) < 20) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        // Once in mid phase, let the block run dry before going on.
        if (p == 2 && n == PHASE_REQS / 2)
          drain_fifo_rsp();
        send_request(r);
      end
      drain_fifo_rsp();
    end

    repeat (12) @(posedge clk);
    fail_cnt += fifo_rsp_q.size();
    if (fail_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
